@@ rtl/core/slt_pkg.sv @@
// Shared types and constants for the shell line tokenizer.
package slt_pkg;

  localparam int MAX_TOKENS = 256;
  localparam int TOK_W      = $clog2(MAX_TOKENS + 1);

  localparam int CHAR_W  = 8;
  localparam int INDEX_W = 8;
  localparam int COUNT_W = 9;

  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LESS    = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_GREATER = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_PIPE    = 8'h7C;
  localparam logic [CHAR_W-1:0] CH_DQUOTE  = 8'h22;
  localparam logic [CHAR_W-1:0] CH_SQUOTE  = 8'h27;

  typedef enum logic [2:0] {
    Q_NONE   = 3'b001,
    Q_SINGLE = 3'b010,
    Q_DOUBLE = 3'b100
  } quote_t;

  typedef enum logic [2:0] {
    P_NONE    = 3'b001,
    P_LESS    = 3'b010,
    P_GREATER = 3'b100
  } pend_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  out_char;
    logic               char_valid;
    logic [INDEX_W-1:0] token_index;
    logic               token_start;
    logic               token_is_operator;
    logic               line_end;
    logic [COUNT_W-1:0] token_count;
  } result_t;

endpackage

@@ rtl/core/slt_in_if.sv @@
// Byte channel into the tokenizer.
interface slt_in_if;
  import slt_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ch;
  logic              last_char;

  modport source (output valid, output ch, output last_char, input ready);
  modport sink (input valid, input ch, input last_char, output ready);
endinterface

@@ rtl/core/slt_out_if.sv @@
// Labelled byte channel out of the tokenizer.
interface slt_out_if;
  import slt_pkg::*;

  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  out_char;
  logic               char_valid;
  logic [INDEX_W-1:0] token_index;
  logic               token_start;
  logic               token_is_operator;
  logic               line_end;
  logic [COUNT_W-1:0] token_count;

  modport source (output valid, output out_char, output char_valid, output token_index,
                  output token_start, output token_is_operator, output line_end,
                  output token_count, input ready);
  modport sink (input valid, input out_char, input char_valid, input token_index,
                input token_start, input token_is_operator, input line_end,
                input token_count, output ready);
endinterface

@@ rtl/core/shell_line_tokenizer.sv @@
// Shell line tokenizer: takes one byte a cycle while the skid register is empty, labelling
// it with token number, token start and operator kind. Each accepted byte yields one result
// word, held in the result register or, under output stall, the skid register; the state
// update is one pass of quote/word/operator logic. A two-deep output (result plus skid
// register) keeps input flowing under output stall until the skid register fills. The final
// byte of a line carries the token count (saturating at MAX_TOKENS) and clears line state.
module shell_line_tokenizer
  import slt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  slt_in_if.sink    chars,
  slt_out_if.source tokens
);

  quote_t           quote_mode, quote_next;
  logic             word_open, word_next;
  pend_t            pending, pend_next;
  logic [TOK_W-1:0] tokens_seen, seen_next;

  logic  begin_tok, valid_c, start_c, is_op_c;
  pend_t kind_c;

  result_t res, out_word, skid_word;
  logic    out_valid, skid_valid;
  logic    in_fire, out_fire;

  assign in_fire  = chars.valid && chars.ready;
  assign out_fire = out_valid && tokens.ready;

  always_comb begin
    quote_next = quote_mode;
    word_next  = word_open;
    pend_next  = pending;
    begin_tok  = 1'b0;
    valid_c    = 1'b1;
    start_c    = 1'b0;
    is_op_c    = 1'b0;
    kind_c     = (chars.ch == CH_LESS) ? P_LESS : P_GREATER;
    case (quote_mode)
      Q_SINGLE: begin
        if (chars.ch == CH_SQUOTE) quote_next = Q_NONE;
      end
      Q_DOUBLE: begin
        if (chars.ch == CH_DQUOTE) quote_next = Q_NONE;
      end
      default: begin
        if (chars.ch == CH_SPACE) begin
          valid_c   = 1'b0;
          word_next = 1'b0;
          pend_next = P_NONE;
        end else if (chars.ch inside {CH_LESS, CH_GREATER}) begin
          is_op_c   = 1'b1;
          word_next = 1'b0;
          // pair with a pending operator of the same kind, else open a new one
          if (pending == kind_c) begin
            pend_next = P_NONE;
          end else begin
            begin_tok = 1'b1;
            start_c   = 1'b1;
            pend_next = kind_c;
          end
        end else if (chars.ch == CH_PIPE) begin
          is_op_c   = 1'b1;
          word_next = 1'b0;
          pend_next = P_NONE;
          begin_tok = 1'b1;
          start_c   = 1'b1;
        end else begin
          pend_next = P_NONE;
          if (!word_open) begin
            begin_tok = 1'b1;
            start_c   = 1'b1;
            word_next = 1'b1;
          end
          if (chars.ch == CH_SQUOTE) quote_next = Q_SINGLE;
          else if (chars.ch == CH_DQUOTE) quote_next = Q_DOUBLE;
        end
      end
    endcase

    seen_next = tokens_seen;
    if (begin_tok && tokens_seen < TOK_W'(MAX_TOKENS)) seen_next = tokens_seen + 1'b1;

    res.out_char          = valid_c ? chars.ch : '0;
    res.char_valid        = valid_c;
    res.token_index       = (valid_c && seen_next != '0) ? INDEX_W'(seen_next - 1'b1) : '0;
    res.token_start       = start_c;
    res.token_is_operator = is_op_c;
    res.line_end          = chars.last_char;
    res.token_count       = chars.last_char ? COUNT_W'(seen_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_mode  <= Q_NONE;
      word_open   <= 1'b0;
      pending     <= P_NONE;
      tokens_seen <= '0;
    end else if (in_fire) begin
      // drop all line state after the final byte
      if (chars.last_char) begin
        quote_mode  <= Q_NONE;
        word_open   <= 1'b0;
        pending     <= P_NONE;
        tokens_seen <= '0;
      end else begin
        quote_mode  <= quote_next;
        word_open   <= word_next;
        pending     <= pend_next;
        tokens_seen <= seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (!out_valid || out_fire) out_word <= res;
      else skid_word <= res;
    end else if (out_fire && skid_valid) begin
      out_word <= skid_word;
    end
  end

  assign chars.ready              = !skid_valid;
  assign tokens.valid             = out_valid;
  assign tokens.out_char          = out_word.out_char;
  assign tokens.char_valid        = out_word.char_valid;
  assign tokens.token_index       = out_word.token_index;
  assign tokens.token_start       = out_word.token_start;
  assign tokens.token_is_operator = out_word.token_is_operator;
  assign tokens.line_end          = out_word.line_end;
  assign tokens.token_count       = out_word.token_count;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held without an output word");

  a_quote_in_word: assert property (@(posedge clk) disable iff (rst)
    quote_mode != Q_NONE |-> word_open && pending == P_NONE)
    else $error("open quote outside a word");

  a_op_not_word: assert property (@(posedge clk) disable iff (rst)
    !(word_open && pending != P_NONE))
    else $error("pending operator inside a word");

  a_line_reset: assert property (@(posedge clk) disable iff (rst)
    in_fire && chars.last_char |=> tokens_seen == '0 && quote_mode == Q_NONE && !word_open)
    else $error("line state not cleared after final byte");

  a_seen_sat: assert property (@(posedge clk) disable iff (rst)
    tokens_seen <= TOK_W'(MAX_TOKENS))
    else $error("token counter past saturation");

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the shell line tokenizer.
module tb_top;
  import slt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 3000;
  localparam int DRAIN_WAIT  = 8;
  localparam int PRINT_LIMIT = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  slt_in_if  chars_if ();
  slt_out_if tokens_if ();

  shell_line_tokenizer u_dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .tokens (tokens_if)
  );

  always #1 clk = ~clk;

  // Predictor state
  quote_t quote_st = Q_NONE;
  pend_t  pend_st  = P_NONE;
  logic   in_word  = 1'b0;
  int     seen     = 0;

  result_t pending_labels[$];
  int      mismatches = 0;
  int      checked    = 0;
  int      idle_count = 0;

  // Sender and receiver control
  int burst_left = 0;
  bit steady     = 1'b0;
  bit hold_req   = 1'b0;

  function automatic void count_token();
    if (seen < MAX_TOKENS) seen++;
  endfunction

  function automatic result_t label_byte(input logic [CHAR_W-1:0] c, input logic last);
    result_t r;
    logic    keep;
    logic    start;
    logic    op;
    pend_t   kind;
    keep  = 1'b1;
    start = 1'b0;
    op    = 1'b0;
    if (quote_st != Q_NONE) begin
      if ((quote_st == Q_SINGLE && c == CH_SQUOTE) || (quote_st == Q_DOUBLE && c == CH_DQUOTE))
        quote_st = Q_NONE;
    end else if (c == CH_SPACE) begin
      keep    = 1'b0;
      in_word = 1'b0;
      pend_st = P_NONE;
    end else if (c inside {CH_LESS, CH_GREATER}) begin
      if (c == CH_LESS) kind = P_LESS;
      else kind = P_GREATER;
      op      = 1'b1;
      in_word = 1'b0;
      // a second equal redirection byte joins the open operator
      if (pend_st == kind) begin
        pend_st = P_NONE;
      end else begin
        count_token();
        start   = 1'b1;
        pend_st = kind;
      end
    end else if (c == CH_PIPE) begin
      op      = 1'b1;
      in_word = 1'b0;
      pend_st = P_NONE;
      count_token();
      start = 1'b1;
    end else begin
      pend_st = P_NONE;
      if (!in_word) begin
        count_token();
        start   = 1'b1;
        in_word = 1'b1;
      end
      if (c == CH_SQUOTE) quote_st = Q_SINGLE;
      else if (c == CH_DQUOTE) quote_st = Q_DOUBLE;
    end
    r.out_char          = keep ? c : '0;
    r.char_valid        = keep;
    r.token_index       = (keep && seen > 0) ? INDEX_W'(seen - 1) : '0;
    r.token_start       = start;
    r.token_is_operator = op;
    r.line_end          = last;
    r.token_count       = last ? COUNT_W'(seen) : '0;
    if (last) begin
      quote_st = Q_NONE;
      pend_st  = P_NONE;
      in_word  = 1'b0;
      seen     = 0;
    end
    return r;
  endfunction

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("%0t: word %0d %s: got %0h, want %0h", $realtime, checked, what, got, want);
  endtask

  // Predict on every accepted byte, check every accepted result word
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst) begin
      if (chars_if.valid && chars_if.ready)
        pending_labels.push_back(label_byte(chars_if.ch, chars_if.last_char));
      if (tokens_if.valid && tokens_if.ready) begin
        got.out_char          = tokens_if.out_char;
        got.char_valid        = tokens_if.char_valid;
        got.token_index       = tokens_if.token_index;
        got.token_start       = tokens_if.token_start;
        got.token_is_operator = tokens_if.token_is_operator;
        got.line_end          = tokens_if.line_end;
        got.token_count       = tokens_if.token_count;
        if (pending_labels.size() == 0) begin
          report("unexpected word", 1, 0);
        end else begin
          want = pending_labels.pop_front();
          if (got.out_char !== want.out_char)
            report("out_char", got.out_char, want.out_char);
          if (got.char_valid !== want.char_valid)
            report("char_valid", got.char_valid, want.char_valid);
          if (got.token_index !== want.token_index)
            report("token_index", got.token_index, want.token_index);
          if (got.token_start !== want.token_start)
            report("token_start", got.token_start, want.token_start);
          if (got.token_is_operator !== want.token_is_operator)
            report("token_is_operator", got.token_is_operator, want.token_is_operator);
          if (got.line_end !== want.line_end)
            report("line_end", got.line_end, want.line_end);
          if (got.token_count !== want.token_count)
            report("token_count", got.token_count, want.token_count);
        end
        checked++;
      end
      if ((chars_if.valid && chars_if.ready) || (tokens_if.valid && tokens_if.ready))
        idle_count = 0;
      else
        idle_count++;
      if (idle_count >= IDLE_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Receiver: stall patterns in segments, plus a long hold-off on request
  initial begin
    int mode;
    int seg_left;
    int period;
    int phase;
    tokens_if.ready = 1'b0;
    seg_left = 0;
    mode     = 0;
    period   = 2;
    phase    = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        tokens_if.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(20, 80);
          mode     = $urandom_range(0, 3);
          period   = $urandom_range(2, 5);
        end
        seg_left--;
        phase++;
        case (mode)
          0: tokens_if.ready = 1'b1;
          1: tokens_if.ready = ($urandom_range(0, 3) != 0);
          2: tokens_if.ready = ((phase % period) != 0);
          default: tokens_if.ready = 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  function automatic logic [CHAR_W-1:0] plain_char();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(1, 255));
    while (c == CH_SPACE || c == CH_LESS || c == CH_GREATER || c == CH_PIPE ||
           c == CH_DQUOTE || c == CH_SQUOTE);
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] special_char();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_LESS;
      2: return CH_GREATER;
      3: return CH_PIPE;
      4: return CH_DQUOTE;
      default: return CH_SQUOTE;
    endcase
  endfunction

  // One command line: words with quoted parts, operators, spaces and some noise
  function automatic void build_line(ref logic [CHAR_W-1:0] line[$]);
    int ntok;
    int n;
    logic [CHAR_W-1:0] c;
    logic [CHAR_W-1:0] qc;
    line.delete();
    ntok = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 7);
    for (int t = 0; t < ntok; t++) begin
      repeat ($urandom_range(0, 2)) line.push_back(CH_SPACE);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          repeat ($urandom_range(0, 4)) line.push_back(plain_char());
          if ($urandom_range(0, 2) == 0) begin
            qc = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
            line.push_back(qc);
            repeat ($urandom_range(0, 4))
              line.push_back($urandom_range(0, 1) ? plain_char() : special_char());
            // leave a few quotes open to the end of the line
            if ($urandom_range(0, 9) != 0) line.push_back(qc);
          end
          repeat ($urandom_range(0, 2)) line.push_back(plain_char());
        end
        5, 6, 7: begin
          case ($urandom_range(0, 2))
            0: c = CH_LESS;
            1: c = CH_GREATER;
            default: c = CH_PIPE;
          endcase
          n = ($urandom_range(0, 7) == 0) ? 3 : $urandom_range(1, 2);
          repeat (n) line.push_back(c);
        end
        8: repeat ($urandom_range(1, 3)) line.push_back(CHAR_W'($urandom_range(1, 255)));
        default: repeat ($urandom_range(1, 4)) line.push_back(special_char());
      endcase
    end
    repeat ($urandom_range(0, 2)) line.push_back(CH_SPACE);
    if (line.size() == 0) line.push_back(plain_char());
  endfunction

  task automatic send_byte(input logic [CHAR_W-1:0] c, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        chars_if.valid     = 1'b0;
        chars_if.ch        = CHAR_W'($urandom);
        chars_if.last_char = 1'($urandom_range(0, 1));
      end
    end
    burst_left--;
    @(negedge clk);
    chars_if.valid     = 1'b1;
    chars_if.ch        = c;
    chars_if.last_char = last;
    do @(posedge clk); while (!chars_if.ready);
  endtask

  task automatic send_seq(input logic [CHAR_W-1:0] line[$]);
    foreach (line[i]) send_byte(line[i], i == line.size() - 1);
  endtask

  task automatic send_text(input string s);
    logic [CHAR_W-1:0] line[$];
    for (int i = 0; i < s.len(); i++) line.push_back(s[i]);
    send_seq(line);
  endtask

  task automatic test_directed();
    // leading and trailing spaces, triple less
    send_text(" a<<<b  ");
    // paired greater, pipe, double quotes holding a single quote and a space, left open
    send_text(">>|\"c'd e");
    // single quotes holding a double quote, space and less; pipes never pair
    send_text("'\" <'||");
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b1);
    // a line of nothing but a space
    send_text(" ");
  endtask

  // More tokens than the counter holds
  task automatic test_saturation();
    logic [CHAR_W-1:0] line[$];
    for (int t = 0; t < MAX_TOKENS + 14; t++) begin
      if ($urandom_range(0, 1)) begin
        line.push_back(CH_PIPE);
      end else begin
        if (line.size() > 0 && line[$] != CH_PIPE) line.push_back(CH_SPACE);
        line.push_back(plain_char());
      end
    end
    send_seq(line);
  endtask

  task automatic test_random_lines(input int n_bytes);
    logic [CHAR_W-1:0] line[$];
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      build_line(line);
      send_seq(line);
      sent += line.size();
    end
  endtask

  // Hold the receiver off while bytes keep coming, so the input stalls
  task automatic test_backpressure();
    hold_req = 1'b1;
    steady   = 1'b1;
    test_random_lines(60);
    steady = 1'b0;
  endtask

  initial begin
    chars_if.valid     = 1'b0;
    chars_if.ch        = '0;
    chars_if.last_char = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_saturation();
    test_random_lines(400);
    test_backpressure();
    test_random_lines(400);

    @(negedge clk);
    chars_if.valid = 1'b0;
    while (pending_labels.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ shell_line_tokenizer.f @@
rtl/core/slt_pkg.sv
rtl/core/slt_in_if.sv
rtl/core/slt_out_if.sv
rtl/core/shell_line_tokenizer.sv
sim/tb_top.sv
